FILE: hw/rtl/qrs_pkg.sv
// Shared constants for the quadratic root solver: default sizes and root count codes.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Number of real roots carried by a result
  localparam logic [1:0] ROOTS_NONE = 2'd0;
  localparam logic [1:0] ROOTS_ONE  = 2'd1;
  localparam logic [1:0] ROOTS_TWO  = 2'd2;

endpackage

FILE: hw/rtl/qrs_front.sv
// Front end: two stages computing coefficient products, the discriminant, root count,
// the scaled numerator base and the divisor. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [COEF_WIDTH-1:0]           in_a,
  input  logic signed [COEF_WIDTH-1:0]           in_b,
  input  logic signed [COEF_WIDTH-1:0]           in_c,
  output logic                                   out_vld,
  output logic [2*COEF_WIDTH+3:0]                out_disc,
  output logic signed [COEF_WIDTH+FRAC_BITS+2:0] out_base,
  output logic signed [COEF_WIDTH:0]             out_den,
  output logic [1:0]                             out_count
);

  localparam int W  = COEF_WIDTH;
  localparam int NW = COEF_WIDTH + FRAC_BITS + 3;
  localparam int DB = 2 * COEF_WIDTH + 4;

  // stage 1: magnitudes and products
  logic [W-1:0]        am, bm, cm;
  logic                v1_r;
  logic signed [W-1:0] a1_r, b1_r, c1_r;
  logic [2*W-1:0]      bb1_r, ac1_r;

  assign am = in_a[W-1] ? W'(-in_a) : W'(in_a);
  assign bm = in_b[W-1] ? W'(-in_b) : W'(in_b);
  assign cm = in_c[W-1] ? W'(-in_c) : W'(in_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= in_a;
      b1_r  <= in_b;
      c1_r  <= in_c;
      bb1_r <= bm * bm;
      ac1_r <= am * cm;
    end
  end

  // stage 2: discriminant and case decode
  logic [DB-1:0]        bb_x, ac4_x, d_sum, d_dif, disc_nxt;
  logic                 ac_pos, d_neg, quad, d_zero;
  logic [1:0]           count_nxt;
  logic signed [NW-1:0] bx, cx, base_nxt;
  logic signed [W:0]    den_nxt;

  assign bb_x   = DB'(bb1_r);
  assign ac4_x  = DB'({ac1_r, 2'b00});
  assign d_sum  = bb_x + ac4_x;
  assign d_dif  = bb_x - ac4_x;
  assign ac_pos = (c1_r != '0) && (a1_r[W-1] == c1_r[W-1]);
  assign d_neg  = ac_pos && (ac4_x > bb_x);
  assign quad   = (a1_r != '0);
  assign d_zero = ac_pos ? (d_dif == '0) : (d_sum == '0);
  assign bx     = NW'(b1_r);
  assign cx     = NW'(c1_r);

  always_comb begin
    disc_nxt = '0;
    if (quad && !d_neg) begin
      disc_nxt = ac_pos ? d_dif : d_sum;
    end
    if (quad) begin
      base_nxt = -(bx <<< FRAC_BITS);
      den_nxt  = {a1_r, 1'b0};
      if (d_neg) begin
        count_nxt = qrs_pkg::ROOTS_NONE;
      end else if (d_zero) begin
        count_nxt = qrs_pkg::ROOTS_ONE;
      end else begin
        count_nxt = qrs_pkg::ROOTS_TWO;
      end
    end else begin
      // linear: root = -c / b
      base_nxt  = -(cx <<< FRAC_BITS);
      den_nxt   = (W + 1)'(b1_r);
      count_nxt = (b1_r != '0) ? qrs_pkg::ROOTS_ONE : qrs_pkg::ROOTS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_disc  <= disc_nxt;
      out_base  <= base_nxt;
      out_den   <= den_nxt;
      out_count <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, of disc * 2^(2*FRAC_BITS).
// Carries an opaque sideband word alongside. No package dependency.
`timescale 1ns / 1ps

module qrs_sqrt #(
  parameter int DISC_W    = 36,
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [DISC_W-1:0]                 in_rad,
  input  logic [SB_W-1:0]                   in_sb,
  output logic                              out_vld,
  output logic [DISC_W/2+FRAC_BITS-1:0]     out_root,
  output logic [SB_W-1:0]                   out_sb
);

  localparam int RW  = DISC_W + 2 * FRAC_BITS;
  localparam int SQ  = RW / 2;
  localparam int RMW = SQ + 2;

  logic            v_r    [1:SQ];
  logic [RW-1:0]   x_r    [1:SQ];
  logic [RMW-1:0]  rem_r  [1:SQ];
  logic [SQ-1:0]   root_r [1:SQ];
  logic [SB_W-1:0] sb_r   [1:SQ];

  for (genvar gi = 0; gi < SQ; gi++) begin : g_stg
    logic            v_s;
    logic [RW-1:0]   x_s;
    logic [RMW-1:0]  rem_s, rem_sh, trial;
    logic [SQ-1:0]   root_s;
    logic [SB_W-1:0] sb_s;
    logic [RMW:0]    diff;
    logic            take;

    if (gi == 0) begin : g_first
      assign v_s    = in_vld;
      assign x_s    = {in_rad, {(2 * FRAC_BITS){1'b0}}};
      assign rem_s  = '0;
      assign root_s = '0;
      assign sb_s   = in_sb;
    end else begin : g_next
      assign v_s    = v_r[gi];
      assign x_s    = x_r[gi];
      assign rem_s  = rem_r[gi];
      assign root_s = root_r[gi];
      assign sb_s   = sb_r[gi];
    end

    assign rem_sh = {rem_s[RMW-3:0], x_s[RW-1 -: 2]};
    assign trial  = {root_s, 2'b01};
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign take   = !diff[RMW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi+1] <= 1'b0;
      end else if (en) begin
        v_r[gi+1] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[gi+1]    <= {x_s[RW-3:0], 2'b00};
        rem_r[gi+1]  <= take ? diff[RMW-1:0] : rem_sh;
        root_r[gi+1] <= {root_s[SQ-2:0], take};
        sb_r[gi+1]   <= sb_s;
      end
    end
  end

  assign out_vld  = v_r[SQ];
  assign out_root = root_r[SQ];
  assign out_sb   = sb_r[SQ];

endmodule

FILE: hw/rtl/qrs_div.sv
// Pipelined signed restoring divider, truncating toward zero, one quotient bit per stage.
// Input stage takes magnitudes, output stage restores the sign. No package dependency.
`timescale 1ns / 1ps

module qrs_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 17,
  parameter int SB_W  = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [NUM_W-1:0] in_num,
  input  logic signed [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]         in_sb,
  output logic                    out_vld,
  output logic signed [NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]         out_sb
);

  logic             v_r   [0:NUM_W];
  logic [NUM_W-1:0] nq_r  [0:NUM_W];
  logic [DEN_W-1:0] dm_r  [0:NUM_W];
  logic [DEN_W-1:0] rem_r [1:NUM_W];
  logic             neg_r [0:NUM_W];
  logic [SB_W-1:0]  sb_r  [0:NUM_W];

  // input stage: magnitudes and result sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
      dm_r[0]  <= in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
      neg_r[0] <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
      sb_r[0]  <= in_sb;
    end
  end

  for (genvar gi = 0; gi < NUM_W; gi++) begin : g_stg
    logic [DEN_W-1:0] rem_s;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             take;

    if (gi == 0) begin : g_first
      assign rem_s = '0;
    end else begin : g_next
      assign rem_s = rem_r[gi];
    end

    assign rem_sh = {rem_s, nq_r[gi][NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dm_r[gi]};
    assign take   = !diff[DEN_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi+1] <= 1'b0;
      end else if (en) begin
        v_r[gi+1] <= v_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi+1] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        nq_r[gi+1]  <= {nq_r[gi][NUM_W-2:0], take};
        dm_r[gi+1]  <= dm_r[gi];
        neg_r[gi+1] <= neg_r[gi];
        sb_r[gi+1]  <= sb_r[gi];
      end
    end
  end

  // output stage: apply sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quo <= neg_r[NUM_W] ? -$signed(nq_r[NUM_W]) : $signed(nq_r[NUM_W]);
      out_sb  <= sb_r[NUM_W];
    end
  end

endmodule

FILE: hw/rtl/quadratic_root_solver_unit.sv
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0 for signed integer coefficients,
// in signed fixed point with FRAC_BITS fraction bits. Fully pipelined: one equation can be
// transferred in every cycle unless the result side stalls, and one result leaves per
// equation, in order. Its stages: two front stages (products, discriminant), one stage per
// square-root bit (COEF_WIDTH+FRAC_BITS+2), the divider's input stage, one stage per quotient
// bit (COEF_WIDTH+FRAC_BITS+3), its sign stage and the output register. The whole pipe
// advances together whenever the output register is empty or being taken, so a stall on
// the result side holds every stage and in_tready drops in the same cycle. root_count is 0
// for a negative discriminant or a = b = 0, 1 for a double root or a linear equation
// (a = 0, root -c/b), 2 otherwise. Roots are truncated toward zero; fields without a root
// read zero. root_first holds the plus-branch or single root, root_second the minus-branch
// root. Depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div.
`timescale 1ns / 1ps

module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  // in_tdata: coef_a, coef_b, coef_c (lowest bits first), zero padded to bytes
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]                     in_tdata,
  input  logic                                                  in_tvalid,
  output logic                                                  in_tready,
  // out_tdata: root_first, root_second (lowest bits first), zero padded to bytes
  output logic [((2*(COEF_WIDTH+FRAC_BITS+3)+7)/8)*8-1:0]       out_tdata,
  // out_tuser: root_count
  output logic [1:0]                                            out_tuser,
  output logic                                                  out_tvalid,
  input  logic                                                  out_tready
);

  localparam int W       = COEF_WIDTH;
  localparam int NW      = COEF_WIDTH + FRAC_BITS + 3;   // root / numerator width
  localparam int DB      = 2 * COEF_WIDTH + 4;           // discriminant width
  localparam int SQ      = DB / 2 + FRAC_BITS;           // square root width
  localparam int SB_W    = NW + W + 1 + 2;
  localparam int OUT_TW  = ((2 * NW + 7) / 8) * 8;

  logic en;

  // pipe advances when the output slot is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- front: products, discriminant, case decode
  logic                 f_vld;
  logic [DB-1:0]        f_disc;
  logic signed [NW-1:0] f_base;
  logic signed [W:0]    f_den;
  logic [1:0]           f_count;

  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid),
    .in_a      (in_tdata[W-1:0]),
    .in_b      (in_tdata[2*W-1:W]),
    .in_c      (in_tdata[3*W-1:2*W]),
    .out_vld   (f_vld),
    .out_disc  (f_disc),
    .out_base  (f_base),
    .out_den   (f_den),
    .out_count (f_count)
  );

  // ---- square root of the scaled discriminant; base, divisor and count ride along
  logic                 s_vld;
  logic [SQ-1:0]        s_root;
  logic [SB_W-1:0]      s_sb;
  logic signed [NW-1:0] s_base;
  logic signed [W:0]    s_den;
  logic [1:0]           s_count;

  qrs_sqrt #(
    .DISC_W    (DB),
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SB_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_rad   (f_disc),
    .in_sb    ({f_base, f_den, f_count}),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_sb   (s_sb)
  );

  assign s_base  = s_sb[SB_W-1 -: NW];
  assign s_den   = s_sb[W+2 -: W+1];
  assign s_count = s_sb[1:0];

  // numerators for both branches; root is zero for single-root and linear cases
  logic signed [NW-1:0] s_ext, num_p, num_m;

  assign s_ext = $signed(NW'(s_root));
  assign num_p = s_base + s_ext;
  assign num_m = s_base - s_ext;

  // ---- two dividers in lockstep
  logic                 dp_vld, dm_vld;
  logic signed [NW-1:0] q_p, q_m;
  logic [1:0]           cnt_p, cnt_m;

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (W + 1),
    .SB_W  (2)
  ) u_div_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s_vld),
    .in_num  (num_p),
    .in_den  (s_den),
    .in_sb   (s_count),
    .out_vld (dp_vld),
    .out_quo (q_p),
    .out_sb  (cnt_p)
  );

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (W + 1),
    .SB_W  (2)
  ) u_div_m (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s_vld),
    .in_num  (num_m),
    .in_den  (s_den),
    .in_sb   (s_count),
    .out_vld (dm_vld),
    .out_quo (q_m),
    .out_sb  (cnt_m)
  );

  // ---- output register; absent roots forced to zero
  logic                 out_tvalid_r;
  logic [1:0]           count_r;
  logic signed [NW-1:0] first_r, second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dp_vld && dm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r  <= cnt_p;
      first_r  <= (cnt_p != qrs_pkg::ROOTS_NONE) ? q_p : '0;
      second_r <= (cnt_m == qrs_pkg::ROOTS_TWO) ? q_m : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = count_r;
  assign out_tdata  = OUT_TW'({second_r, first_r});

endmodule
